// ----- rtl/fsed_pkg.sv -----
// fsed_pkg: shared constants, types and arithmetic helpers of the error diffusion core
package fsed_pkg;

  // sizing
  localparam int MAX_WIDTH  = 2048;
  localparam int ERROR_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WCOUNT_W   = $clog2(MAX_WIDTH + 1);

  // field widths
  localparam int SAMPLE_W    = 13;
  localparam int LEVEL_W     = 8;
  localparam int STEP_W      = 13;
  localparam int GAIN_W      = 13;
  localparam int IMG_W       = 12;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int ROW_W       = 3 * ERROR_BITS;

  // datapath widths
  localparam int FULL_SCALE  = 4096;
  localparam int V_W         = ERROR_BITS + 3;
  localparam int Q_W         = V_W + LEVEL_W + 1;
  localparam int QUANT_SHIFT = 12;
  localparam int QUANT_ROUND = 2048;
  localparam int L_W         = Q_W - QUANT_SHIFT;
  localparam int P_W         = LEVEL_W + STEP_W;
  localparam int D_W         = ((V_W > P_W + 1) ? V_W : P_W + 1) + 1;
  localparam int G_W         = ERROR_BITS + GAIN_W + 1;
  localparam int M_W         = G_W + 3;
  localparam int SHARE_SHIFT = 16;
  localparam int SHARE_ROUND = 32768;

  // diffusion weights in sixteenths
  localparam int W_AHEAD        = 7;
  localparam int W_BEHIND_BELOW = 3;
  localparam int W_BELOW        = 5;
  localparam int W_AHEAD_BELOW  = 1;

  // saturation limits of a carried error
  localparam logic signed [D_W-1:0] ERR_HI = D_W'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
  localparam logic signed [D_W-1:0] ERR_LO = D_W'(-(64'sd1 <<< (ERROR_BITS - 1)));

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVELS  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SERPENT = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH   = CFG_INDEX_W'(4);

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_LEVELS  = LEVEL_W'(1);
  localparam logic [STEP_W-1:0]  RST_STEP    = STEP_W'(4096);
  localparam logic [GAIN_W-1:0]  RST_GAIN    = GAIN_W'(4096);
  localparam logic               RST_SERPENT = 1'b1;
  localparam logic [IMG_W-1:0]   RST_WIDTH   = IMG_W'(2048);

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_LVL,
    ST_ERR,
    ST_GAIN,
    ST_SHARE,
    ST_LAST,
    ST_OUT
  } state_t;

  // per-step strobes to the channel lanes
  typedef struct packed {
    logic clr;
    logic ld_sum;
    logic ld_lvl;
    logic ld_err;
    logic ld_gain;
    logic ld_share;
    logic last;
  } lane_ctrl_t;

  // quantizer and gain settings seen by every lane
  typedef struct packed {
    logic [LEVEL_W-1:0] levels_minus_one;
    logic [STEP_W-1:0]  level_step;
    logic [GAIN_W-1:0]  diffusion_gain;
  } lane_cfg_t;

  // clamp to the carried error range
  function automatic logic signed [ERROR_BITS-1:0] sat_err(input logic signed [D_W-1:0] x);
    if (x > ERR_HI) return ERROR_BITS'(ERR_HI);
    if (x < ERR_LO) return ERROR_BITS'(ERR_LO);
    return ERROR_BITS'(x);
  endfunction

  // round(g * wgt / 65536), ties toward plus infinity
  function automatic logic signed [ERROR_BITS-1:0] share(input logic signed [G_W-1:0] g,
                                                         input int wgt);
    logic signed [M_W-1:0] m;
    m = M_W'(g) * M_W'(wgt);
    m = m + M_W'(SHARE_ROUND);
    return ERROR_BITS'(m >>> SHARE_SHIFT);
  endfunction

endpackage

// ----- rtl/fsed_ram.sv -----
// fsed_ram: generic simple dual port ram with registered read
module fsed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fsed_lane.sv -----
// fsed_lane: one color channel: error sum, quantizer, gain and error shares
module fsed_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fsed_pkg::lane_ctrl_t                   ctrl,
  input  fsed_pkg::lane_cfg_t                    cfg,
  input  logic [fsed_pkg::SAMPLE_W-1:0]          sample,
  input  logic signed [fsed_pkg::ERROR_BITS-1:0] row_err,
  output logic [fsed_pkg::LEVEL_W-1:0]           level,
  output logic signed [fsed_pkg::ERROR_BITS-1:0] below_data,
  output logic signed [fsed_pkg::ERROR_BITS-1:0] last_data
);

  logic [fsed_pkg::SAMPLE_W-1:0]          s_clamp;
  logic signed [fsed_pkg::V_W-1:0]        v, v_next;
  logic signed [fsed_pkg::Q_W-1:0]        q;
  logic signed [fsed_pkg::L_W-1:0]        l_raw, lmo_ext;
  logic [fsed_pkg::LEVEL_W-1:0]           lvl, lvl_next;
  logic [fsed_pkg::P_W-1:0]               p;
  logic signed [fsed_pkg::D_W-1:0]        d;
  logic signed [fsed_pkg::ERROR_BITS-1:0] e, e_next;
  logic signed [fsed_pkg::G_W-1:0]        g, g_next;
  logic signed [fsed_pkg::ERROR_BITS-1:0] s7, s3, s5, s1, sum5;
  logic signed [fsed_pkg::ERROR_BITS-1:0] ahead, bps0, bps1;

  // sample, clamped to full scale, plus carried errors
  always_comb begin
    s_clamp = (sample > fsed_pkg::SAMPLE_W'(fsed_pkg::FULL_SCALE)) ?
              fsed_pkg::SAMPLE_W'(fsed_pkg::FULL_SCALE) : sample;
    v_next = fsed_pkg::V_W'($signed({1'b0, s_clamp})) + fsed_pkg::V_W'(ahead)
           + fsed_pkg::V_W'(row_err);
  end

  // rounded level, limited to the level range
  always_comb begin
    q       = fsed_pkg::Q_W'(v) * fsed_pkg::Q_W'($signed({1'b0, cfg.levels_minus_one}));
    q       = q + fsed_pkg::Q_W'(fsed_pkg::QUANT_ROUND);
    l_raw   = fsed_pkg::L_W'(q >>> fsed_pkg::QUANT_SHIFT);
    lmo_ext = fsed_pkg::L_W'($signed({1'b0, cfg.levels_minus_one}));
    if (l_raw < fsed_pkg::L_W'(0)) begin
      lvl_next = '0;
    end else if (l_raw > lmo_ext) begin
      lvl_next = cfg.levels_minus_one;
    end else begin
      lvl_next = fsed_pkg::LEVEL_W'(l_raw);
    end
  end

  // quantization error and its gain
  always_comb begin
    p      = fsed_pkg::P_W'(lvl) * fsed_pkg::P_W'(cfg.level_step);
    d      = fsed_pkg::D_W'(v) - fsed_pkg::D_W'($signed({1'b0, p}));
    e_next = fsed_pkg::sat_err(d);
    g_next = fsed_pkg::G_W'(e) * fsed_pkg::G_W'($signed({1'b0, cfg.diffusion_gain}));
  end

  // the four shares and the next-row sums
  always_comb begin
    s7 = fsed_pkg::share(g, fsed_pkg::W_AHEAD);
    s3 = fsed_pkg::share(g, fsed_pkg::W_BEHIND_BELOW);
    s5 = fsed_pkg::share(g, fsed_pkg::W_BELOW);
    s1 = fsed_pkg::share(g, fsed_pkg::W_AHEAD_BELOW);
    below_data = fsed_pkg::sat_err(fsed_pkg::D_W'(bps0) + fsed_pkg::D_W'(s3));
    sum5       = fsed_pkg::sat_err(fsed_pkg::D_W'(bps1) + fsed_pkg::D_W'(s5));
  end

  // step registers
  always_ff @(posedge clk) begin
    if (ctrl.ld_sum)   v         <= v_next;
    if (ctrl.ld_lvl)   lvl       <= lvl_next;
    if (ctrl.ld_err)   e         <= e_next;
    if (ctrl.ld_gain)  g         <= g_next;
    if (ctrl.ld_share) last_data <= sum5;
  end

  // errors carried along the row
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      ahead <= '0;
      bps0  <= '0;
      bps1  <= '0;
    end else if (ctrl.ld_share) begin
      ahead <= ctrl.last ? '0 : s7;
      bps0  <= ctrl.last ? '0 : sum5;
      bps1  <= ctrl.last ? '0 : s1;
    end
  end

  assign level = lvl;

endmodule

// ----- rtl/floyd_steinberg_error_diffusion_core.sv -----
// floyd_steinberg_error_diffusion_core: serpentine error diffusion dither with a line store
//
// Pixels come in on the s_axis word channel in visiting order (raster, odd rows right
// to left when serpentine mode is set); each word gives one result word on m_axis with
// the three level indexes and tlast on the last pixel of a row.
// Registers are written over the cfg channel (index, data), always ready; write them
// only while no pixel is in flight.
// An item is taken while idle, then walks through sum, level, error, gain and share steps
// of the three channel lanes, a write back into the line store (one more step on the last
// pixel of a row) and an output step; one pixel at a time, set by the read, modify, write
// of the line store entry and the feedback of the ahead error into the next pixel.
// A pixel with tuser set starts a frame: before it is handled, the line store is swept
// to zero one entry a cycle over all MAX_WIDTH entries, then its entry is read in the
// read state.
// After reset the same sweep of all MAX_WIDTH entries runs before s_axis_tready rises.
// The result sits in an output register; while the receiver stalls, the next pixel is
// still taken and worked on, and waits in its last step until the register frees.
module floyd_steinberg_error_diffusion_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // cfg write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fsed_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fsed_pkg::CFG_DATA_W-1:0]      cfg_data,
  // pixel input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fsed_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                                 s_axis_tuser,   // frame_start
  // level output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fsed_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // red, green, blue level
  output logic                                 m_axis_tlast    // row_done
);

  localparam int E  = fsed_pkg::ERROR_BITS;
  localparam int AW = fsed_pkg::ADDR_W;
  localparam int WW = fsed_pkg::WCOUNT_W;
  localparam int SW = fsed_pkg::SAMPLE_W;

  fsed_pkg::state_t state, state_next;

  // configuration registers
  logic [fsed_pkg::LEVEL_W-1:0] levels_minus_one;
  logic [fsed_pkg::STEP_W-1:0]  level_step;
  logic [fsed_pkg::GAIN_W-1:0]  diffusion_gain;
  logic                         serpentine_mode;
  logic [fsed_pkg::IMG_W-1:0]   image_width;

  // scan position and sweep
  logic [AW-1:0] column_count;
  logic          row_odd;
  logic [AW-1:0] clr_cnt;
  logic          clr_pend;
  logic          clr_done;

  // held pixel
  logic [SW-1:0] red, green, blue;

  // position decode
  logic [WW-1:0] w, i_w;
  logic [AW-1:0] x, xb, col_inc;
  logic          rev, last, behind;

  // sequencer outputs
  logic                 accept, frame_accept, out_load, pos_step;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [fsed_pkg::ROW_W-1:0] ram_wdata, ram_rdata;
  fsed_pkg::lane_ctrl_t lane_ctrl;
  fsed_pkg::lane_cfg_t  lane_cfg;

  // lane results
  logic [fsed_pkg::LEVEL_W-1:0] lvl_r, lvl_g, lvl_b;
  logic signed [E-1:0] below_r, below_g, below_b, lastd_r, lastd_g, lastd_b;

  assign cfg_ready    = 1'b1;
  assign accept       = s_axis_tvalid && s_axis_tready;
  assign frame_accept = accept && s_axis_tuser;
  assign clr_done     = (clr_cnt == AW'(fsed_pkg::MAX_WIDTH - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_minus_one <= fsed_pkg::RST_LEVELS;
      level_step       <= fsed_pkg::RST_STEP;
      diffusion_gain   <= fsed_pkg::RST_GAIN;
      serpentine_mode  <= fsed_pkg::RST_SERPENT;
      image_width      <= fsed_pkg::RST_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fsed_pkg::CFG_LEVELS:  levels_minus_one <= cfg_data[fsed_pkg::LEVEL_W-1:0];
        fsed_pkg::CFG_STEP:    level_step       <= cfg_data[fsed_pkg::STEP_W-1:0];
        fsed_pkg::CFG_GAIN:    diffusion_gain   <= cfg_data[fsed_pkg::GAIN_W-1:0];
        fsed_pkg::CFG_SERPENT: serpentine_mode  <= cfg_data[0];
        fsed_pkg::CFG_WIDTH:   image_width      <= cfg_data[fsed_pkg::IMG_W-1:0];
        default: ;
      endcase
    end
  end

  // row width, column and store addresses of the current pixel
  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > 32'(fsed_pkg::MAX_WIDTH)) begin
      w = WW'(fsed_pkg::MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    i_w     = (WW'(column_count) >= w) ? w - WW'(1) : WW'(column_count);
    rev     = row_odd && serpentine_mode;
    x       = rev ? AW'(w - WW'(1) - i_w) : AW'(i_w);
    xb      = rev ? AW'(w - i_w) : AW'(i_w - WW'(1));
    last    = (i_w + WW'(1) >= w);
    behind  = (i_w != '0);
    col_inc = AW'(i_w + WW'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fsed_pkg::ST_CLEAR: begin
        if (clr_done) state_next = clr_pend ? fsed_pkg::ST_READ : fsed_pkg::ST_IDLE;
      end
      fsed_pkg::ST_IDLE: begin
        if (accept) state_next = s_axis_tuser ? fsed_pkg::ST_CLEAR : fsed_pkg::ST_SUM;
      end
      fsed_pkg::ST_READ:  state_next = fsed_pkg::ST_SUM;
      fsed_pkg::ST_SUM:   state_next = fsed_pkg::ST_LVL;
      fsed_pkg::ST_LVL:   state_next = fsed_pkg::ST_ERR;
      fsed_pkg::ST_ERR:   state_next = fsed_pkg::ST_GAIN;
      fsed_pkg::ST_GAIN:  state_next = fsed_pkg::ST_SHARE;
      fsed_pkg::ST_SHARE: state_next = last ? fsed_pkg::ST_LAST : fsed_pkg::ST_OUT;
      fsed_pkg::ST_LAST:  state_next = fsed_pkg::ST_OUT;
      fsed_pkg::ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = fsed_pkg::ST_IDLE;
      end
      default: state_next = fsed_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready      = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_waddr          = x;
    ram_wdata          = {lastd_b, lastd_g, lastd_r};
    out_load           = 1'b0;
    pos_step           = 1'b0;
    lane_ctrl          = '0;
    lane_ctrl.last     = last;
    lane_ctrl.clr      = frame_accept;
    unique case (state)
      fsed_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      fsed_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid && !s_axis_tuser;
      end
      fsed_pkg::ST_READ:  ram_re            = 1'b1;
      fsed_pkg::ST_SUM:   lane_ctrl.ld_sum  = 1'b1;
      fsed_pkg::ST_LVL:   lane_ctrl.ld_lvl  = 1'b1;
      fsed_pkg::ST_ERR:   lane_ctrl.ld_err  = 1'b1;
      fsed_pkg::ST_GAIN:  lane_ctrl.ld_gain = 1'b1;
      fsed_pkg::ST_SHARE: begin
        lane_ctrl.ld_share = 1'b1;
        ram_we             = behind;
        ram_waddr          = xb;
        ram_wdata          = {below_b, below_g, below_r};
      end
      fsed_pkg::ST_LAST:  ram_we = 1'b1;
      fsed_pkg::ST_OUT: begin
        out_load = !m_axis_tvalid || m_axis_tready;
        pos_step = out_load;
      end
      default: ;
    endcase
  end

  // state, sweep counter and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fsed_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      clr_pend     <= 1'b0;
      column_count <= '0;
      row_odd      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == fsed_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_done) clr_pend <= 1'b0;
      end
      if (frame_accept) begin
        clr_cnt      <= '0;
        clr_pend     <= 1'b1;
        column_count <= '0;
        row_odd      <= 1'b0;
      end else if (pos_step) begin
        column_count <= last ? '0 : col_inc;
        if (last) row_odd <= !row_odd;
      end
    end
  end

  // held pixel samples
  always_ff @(posedge clk) begin
    if (accept) begin
      red   <= s_axis_tdata[SW-1:0];
      green <= s_axis_tdata[2*SW-1:SW];
      blue  <= s_axis_tdata[3*SW-1:2*SW];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {lvl_b, lvl_g, lvl_r};
      m_axis_tlast <= last;
    end
  end

  // line store of next-row errors
  fsed_ram #(
    .WIDTH (fsed_pkg::ROW_W),
    .DEPTH (fsed_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (x),
    .rdata (ram_rdata)
  );

  // channel lanes
  assign lane_cfg.levels_minus_one = levels_minus_one;
  assign lane_cfg.level_step       = level_step;
  assign lane_cfg.diffusion_gain   = diffusion_gain;

  fsed_lane u_red (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .cfg        (lane_cfg),
    .sample     (red),
    .row_err    ($signed(ram_rdata[E-1:0])),
    .level      (lvl_r),
    .below_data (below_r),
    .last_data  (lastd_r)
  );

  fsed_lane u_green (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .cfg        (lane_cfg),
    .sample     (green),
    .row_err    ($signed(ram_rdata[2*E-1:E])),
    .level      (lvl_g),
    .below_data (below_g),
    .last_data  (lastd_g)
  );

  fsed_lane u_blue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane_ctrl),
    .cfg        (lane_cfg),
    .sample     (blue),
    .row_err    ($signed(ram_rdata[3*E-1:2*E])),
    .level      (lvl_b),
    .below_data (below_b),
    .last_data  (lastd_b)
  );

endmodule
